// ===== design/overlay_blend_yuv420_block_assert.svh =====
// Assertion macros for the overlay blend design files; obl_mix is the one that uses them.
// Each macro expects a clock named clk and a synchronous reset named rst.
`ifndef OVERLAY_BLEND_YUV420_BLOCK_ASSERT_SVH
`define OVERLAY_BLEND_YUV420_BLOCK_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define OBL_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("overlay blend check failed");

// The consequent must hold in the cycle after the antecedent.
`define OBL_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("overlay blend check failed");

`endif

// ===== design/obl_pkg.sv =====
package obl_pkg;

  localparam int NumPx = 4;

  typedef enum logic [1:0] {
    CASE_OPAQUE = 2'd0,
    CASE_BLEND  = 2'd1,
    CASE_TRANSP = 2'd2
  } blend_case_t;

  // Input word as it arrives on s_tdata; the first member sits in the top bits.
  typedef struct packed {
    logic [7:0]              bgv;
    logic [7:0]              bgu;
    logic [NumPx-1:0][7:0]   bgl;
    logic [NumPx-1:0][31:0]  px;
  } in_t;

  typedef struct packed {
    logic [NumPx-1:0][7:0] inv;
    logic [NumPx-1:0][7:0] lum;
    logic [NumPx-1:0][7:0] bgl;
    logic [7:0]            weight;
    logic [7:0]            avg_u;
    logic [7:0]            avg_v;
    logic [7:0]            bgu;
    logic [7:0]            bgv;
    blend_case_t           bcase;
  } prep_t;

  typedef struct packed {
    logic [NumPx-1:0][7:0] scl;
    logic [NumPx-1:0][7:0] lum;
    logic [NumPx-1:0][7:0] bgl;
    logic [7:0]            scu;
    logic [7:0]            scv;
    logic [7:0]            avg_u;
    logic [7:0]            avg_v;
    logic [7:0]            bgu;
    logic [7:0]            bgv;
    blend_case_t           bcase;
  } mul_t;

  typedef struct packed {
    blend_case_t           bcase;
    logic [7:0]            v;
    logic [7:0]            u;
    logic [NumPx-1:0][7:0] luma;
  } out_t;

endpackage

// ===== design/obl_prep.sv =====
module obl_prep (
  input  logic         clk,
  input  logic         rst,
  input  logic         in_valid,
  output logic         in_ready,
  input  obl_pkg::in_t in_data,
  output logic         out_valid,
  input  logic         out_ready,
  output obl_pkg::prep_t out_data
);
  import obl_pkg::*;

  prep_t      nxt;
  logic [9:0] sum_inv;
  logic [9:0] sum_u;
  logic [9:0] sum_v;

  // Inverse alpha per pixel, block sums and the blend decision.
  always_comb begin
    sum_inv = '0;
    sum_u   = '0;
    sum_v   = '0;
    for (int i = 0; i < NumPx; i++) begin
      nxt.inv[i] = 8'd255 - in_data.px[i][31:24];
      nxt.lum[i] = in_data.px[i][23:16];
      nxt.bgl[i] = in_data.bgl[i];
      sum_inv    = sum_inv + {2'b00, nxt.inv[i]};
      sum_u      = sum_u + {2'b00, in_data.px[i][15:8]};
      sum_v      = sum_v + {2'b00, in_data.px[i][7:0]};
    end
    nxt.weight = sum_inv[9:2];
    nxt.avg_u  = sum_u[9:2];
    nxt.avg_v  = sum_v[9:2];
    nxt.bgu    = in_data.bgu;
    nxt.bgv    = in_data.bgv;
    priority if (nxt.weight == 8'd0) begin
      nxt.bcase = CASE_OPAQUE;
    end else if (nxt.weight == 8'd255) begin
      nxt.bcase = CASE_TRANSP;
    end else begin
      nxt.bcase = CASE_BLEND;
    end
  end

  assign in_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      out_data <= nxt;
    end
  end

endmodule

// ===== design/obl_mul.sv =====
module obl_mul (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  obl_pkg::prep_t in_data,
  output logic           out_valid,
  input  logic           out_ready,
  output obl_pkg::mul_t  out_data
);
  import obl_pkg::*;

  mul_t        nxt;
  logic [15:0] prod_l [NumPx];
  logic [15:0] prod_u;
  logic [15:0] prod_v;

  // Luma scales by each pixel's own inverse alpha, chroma by the block weight.
  always_comb begin
    for (int i = 0; i < NumPx; i++) begin
      prod_l[i]  = {8'd0, in_data.bgl[i]} * {8'd0, in_data.inv[i]};
      nxt.scl[i] = prod_l[i][15:8];
    end
    prod_u    = {8'd0, in_data.bgu} * {8'd0, in_data.weight};
    prod_v    = {8'd0, in_data.bgv} * {8'd0, in_data.weight};
    nxt.scu   = prod_u[15:8];
    nxt.scv   = prod_v[15:8];
    nxt.lum   = in_data.lum;
    nxt.bgl   = in_data.bgl;
    nxt.avg_u = in_data.avg_u;
    nxt.avg_v = in_data.avg_v;
    nxt.bgu   = in_data.bgu;
    nxt.bgv   = in_data.bgv;
    nxt.bcase = in_data.bcase;
  end

  assign in_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      out_data <= nxt;
    end
  end

endmodule

// ===== design/obl_mix.sv =====
`include "overlay_blend_yuv420_block_assert.svh"

module obl_mix (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  obl_pkg::mul_t in_data,
  output logic          out_valid,
  input  logic          out_ready,
  output obl_pkg::out_t out_data
);
  import obl_pkg::*;

  out_t nxt;

  function automatic logic [7:0] sat_add(input logic [7:0] a, input logic [7:0] b);
    logic [8:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[8] ? 8'hFF : s[7:0];
  endfunction

  always_comb begin
    nxt.bcase = in_data.bcase;
    unique case (in_data.bcase)
      CASE_OPAQUE: begin
        nxt.luma = in_data.lum;
        nxt.u    = in_data.avg_u;
        nxt.v    = in_data.avg_v;
      end
      CASE_BLEND: begin
        for (int i = 0; i < NumPx; i++) begin
          nxt.luma[i] = sat_add(in_data.scl[i], in_data.lum[i]);
        end
        nxt.u = sat_add(in_data.scu, in_data.avg_u);
        nxt.v = sat_add(in_data.scv, in_data.avg_v);
      end
      default: begin
        nxt.luma = in_data.bgl;
        nxt.u    = in_data.bgu;
        nxt.v    = in_data.bgv;
      end
    endcase
  end

  assign in_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      out_data <= nxt;
    end
  end

  `OBL_ASSERT_NEXT(a_take_fills, in_valid && in_ready, out_valid)
  `OBL_ASSERT_NEXT(a_transp_keeps_bg,
    in_valid && in_ready && in_data.bcase == CASE_TRANSP,
    out_data.luma == $past(in_data.bgl) && out_data.u == $past(in_data.bgu))
  `OBL_ASSERT_NEXT(a_blend_no_wrap,
    in_valid && in_ready && in_data.bcase == CASE_BLEND,
    out_data.luma[0] >= $past(in_data.lum[0]) && out_data.v >= $past(in_data.avg_v))
  `OBL_ASSERT_SAME(a_empty_ready, !out_valid, in_ready)

endmodule

// ===== design/overlay_blend_yuv420_block.sv =====
// Overlay blend for one 2x2 block of a 4:2:0 picture.
// The slave stream carries one word per block: four packed overlay pixels
// (alpha, Y, U, V) and the background luma, U and V bytes under them.
// The master stream returns one word per block with the four blended luma
// bytes, the blended U and V bytes, and the blend case on m_tuser.
// The pipeline has three register stages: block sums and the blend decision,
// the six 8x8 background scalings, and the saturating add with the case
// select. A word accepted on s_tdata is registered in the prep, mul and mix
// stages in that order before it shows on m_tvalid. One word can be accepted
// every cycle while the output is not stalled; the throughput is one
// block per clock, since every stage takes a new word in each cycle in
// which the stage after it is empty or moves its word on.
// Each stage holds its own valid bit and may load whenever it is empty or
// its contents move on, so bubbles close up even while the output waits.
// When the receiver holds m_tready low, the result stays on m_tdata and the
// stalls back up stage by stage; s_tready falls only once all three stages
// are full. Nothing is dropped or repeated.
// A synchronous reset clears the valid bits; no data words are in flight
// afterwards and s_tready is high in the next cycle.
module overlay_blend_yuv420_block (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  // Fields from bit 0 up: overlay_px_top_left, overlay_px_top_right,
  // overlay_px_bot_left, overlay_px_bot_right (32 each), bg_luma_top_left,
  // bg_luma_top_right, bg_luma_bot_left, bg_luma_bot_right, bg_chroma_u,
  // bg_chroma_v (8 each).
  input  logic [175:0] s_tdata,
  output logic         m_tvalid,
  input  logic         m_tready,
  // Fields from bit 0 up: out_luma_top_left, out_luma_top_right,
  // out_luma_bot_left, out_luma_bot_right, out_chroma_u, out_chroma_v
  // (8 each).
  output logic [47:0]  m_tdata,
  // Field: blend_case (0 opaque copy, 1 blended, 2 transparent).
  output logic [1:0]   m_tuser
);
  import obl_pkg::*;

  in_t   in_word;
  prep_t prep_data;
  mul_t  mul_data;
  out_t  out_data;
  logic  prep_valid;
  logic  prep_ready;
  logic  mul_valid;
  logic  mul_ready;

  // The packed input struct lays its fields out exactly as the bus does.
  assign in_word = in_t'(s_tdata);

  obl_prep u_prep (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .in_data   (in_word),
    .out_valid (prep_valid),
    .out_ready (prep_ready),
    .out_data  (prep_data)
  );

  obl_mul u_mul (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (prep_valid),
    .in_ready  (prep_ready),
    .in_data   (prep_data),
    .out_valid (mul_valid),
    .out_ready (mul_ready),
    .out_data  (mul_data)
  );

  obl_mix u_mix (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (mul_valid),
    .in_ready  (mul_ready),
    .in_data   (mul_data),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_data  (out_data)
  );

  // The case code rides on tuser; the six bytes fill tdata from the bottom.
  assign m_tdata = {out_data.v, out_data.u, out_data.luma};
  assign m_tuser = out_data.bcase;

endmodule
